// File: design/gfmpi_pkg.sv
// Shared types, constants, microcode table and GF(2^128) arithmetic functions.
package gfmpi_pkg;

  // Field and datapath sizes
  localparam int ElemW       = 128;
  localparam int HalfW       = 64;
  localparam int DigitW      = 32;
  localparam int NumDigits   = ElemW / DigitW;
  localparam int DigitIdxW   = $clog2(NumDigits);
  localparam int ProdW       = ElemW + DigitW - 1;
  localparam int ExponentBits = 32;
  localparam int InvIters    = 128;
  localparam int CntW        = $clog2(InvIters + 1);

  typedef logic [ElemW-1:0] elem_t;

  // Command codes
  localparam logic [1:0] CmdMul = 2'd0;
  localparam logic [1:0] CmdPow = 2'd1;
  localparam logic [1:0] CmdInv = 2'd2;
  localparam logic [1:0] CmdMac = 2'd3;

  // Datapath operations of one control word
  typedef enum logic [2:0] {
    OpIdle,
    OpNop,
    OpMul,
    OpAccP,
    OpMacAdd,
    OpSqr,
    OpOut
  } op_e;

  // Jump conditions: taken means go to target, else fall through to pc + 1 (CondStart dispatches)
  typedef enum logic [2:0] {
    CondNone,
    CondAlways,
    CondStart,
    CondMulBusy,
    CondNoBit,
    CondMore,
    CondOutBusy
  } cond_e;

  // Program addresses
  localparam int PcW = 4;
  localparam logic [PcW-1:0] PcIdle    = 4'd0;
  localparam logic [PcW-1:0] PcMulB    = 4'd1;
  localparam logic [PcW-1:0] PcMovB    = 4'd2;
  localparam logic [PcW-1:0] PcMacM    = 4'd3;
  localparam logic [PcW-1:0] PcMacA    = 4'd4;
  localparam logic [PcW-1:0] PcSqr     = 4'd5;
  localparam logic [PcW-1:0] PcMulX    = 4'd6;
  localparam logic [PcW-1:0] PcMovX    = 4'd7;
  localparam logic [PcW-1:0] PcLoopEnd = 4'd8;
  localparam logic [PcW-1:0] PcOut     = 4'd9;
  localparam int NumSteps = 10;

  typedef struct packed {
    op_e            op;
    cond_e          cond;
    logic [PcW-1:0] target;
    logic           sel_b;   // multiply by operand b instead of operand a
  } ucode_t;

  localparam ucode_t Ucode [NumSteps] = '{
    '{OpIdle,   CondStart,   PcIdle,    1'b0},  // wait for an item, dispatch
    '{OpMul,    CondMulBusy, PcMulB,    1'b1},  // acc * b
    '{OpAccP,   CondAlways,  PcOut,     1'b0},
    '{OpMul,    CondMulBusy, PcMacM,    1'b1},  // acc * b for accumulate
    '{OpMacAdd, CondAlways,  PcOut,     1'b0},
    '{OpSqr,    CondNoBit,   PcLoopEnd, 1'b0},  // square, skip multiply on zero bit
    '{OpMul,    CondMulBusy, PcMulX,    1'b0},  // acc * a
    '{OpAccP,   CondNone,    PcLoopEnd, 1'b0},
    '{OpNop,    CondMore,    PcSqr,     1'b0},  // next exponent bit
    '{OpOut,    CondOutBusy, PcOut,     1'b0}   // hand result to output register
  };

  // Entry point of each command's program
  function automatic logic [PcW-1:0] entry_pc(logic [1:0] cmd);
    logic [PcW-1:0] pc;
    unique case (cmd)
      CmdMul:  pc = PcMulB;
      CmdMac:  pc = PcMacM;
      default: pc = PcSqr;
    endcase
    return pc;
  endfunction

  // Carry-less product of an element and one digit
  function automatic logic [ProdW-1:0] clmul_digit(elem_t a, logic [DigitW-1:0] d);
    logic [ProdW-1:0] acc;
    acc = '0;
    for (int i = 0; i < DigitW; i++) begin
      if (d[i]) acc = acc ^ (ProdW'(a) << i);
    end
    return acc;
  endfunction

  // One Horner step: p * x^DigitW + a * d, reduced
  function automatic elem_t mul_step(elem_t p, elem_t a, logic [DigitW-1:0] d);
    logic [ElemW+DigitW-1:0] s;
    logic [DigitW-1:0]       u;
    logic [DigitW+6:0]       t;
    s = {p, {DigitW{1'b0}}} ^ (ElemW + DigitW)'(clmul_digit(a, d));
    u = s[ElemW+DigitW-1:ElemW];
    t = (DigitW + 7)'(u) ^ ((DigitW + 7)'(u) << 1) ^ ((DigitW + 7)'(u) << 2)
      ^ ((DigitW + 7)'(u) << 7);
    return s[ElemW-1:0] ^ ElemW'(t);
  endfunction

  // Field squaring: spread bits, then fold the upper half twice
  function automatic elem_t gf_square(elem_t a);
    logic [2*ElemW-1:0] w;
    logic [ElemW-1:0]   u;
    logic [ElemW+6:0]   t;
    logic [6:0]         o;
    w = '0;
    for (int i = 0; i < ElemW; i++) begin
      w[2*i] = a[i];
    end
    u = w[2*ElemW-1:ElemW];
    t = (ElemW + 7)'(u) ^ ((ElemW + 7)'(u) << 1) ^ ((ElemW + 7)'(u) << 2)
      ^ ((ElemW + 7)'(u) << 7);
    o = t[ElemW+6:ElemW];
    return w[ElemW-1:0] ^ t[ElemW-1:0] ^ ElemW'(o) ^ (ElemW'(o) << 1)
         ^ (ElemW'(o) << 2) ^ (ElemW'(o) << 7);
  endfunction

endpackage

// File: design/gfmpi_if.sv
// Input and output channel interfaces of the GF(2^128) unit.
interface gfmpi_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [63:0] a_low;
  logic [63:0] a_high;
  logic [63:0] b_low;
  logic [63:0] b_high;
  logic [31:0] exponent;
  logic        restart;

  modport source (output valid, command, a_low, a_high, b_low, b_high, exponent, restart,
                  input ready);
  modport sink   (input valid, command, a_low, a_high, b_low, b_high, exponent, restart,
                  output ready);
endinterface

interface gfmpi_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_low;
  logic [63:0] result_high;

  modport source (output valid, result_low, result_high, input ready);
  modport sink   (input valid, result_low, result_high, output ready);
endinterface

// File: design/gf128_multiply_power_inverse_unit.sv
// Top level: microcoded GF(2^128) multiply, power, inverse and multiply-accumulate unit.
// Works one item at a time. The field multiplier is digit-serial, 32 bits of the
// multiplier operand per cycle, and squaring is a single control step. A new item
// is taken the cycle after the result is loaded into the output register, which
// holds it while the sink stalls.
// Reduction polynomial x^128 + x^7 + x^2 + x + 1, plain bit order.
module gf128_multiply_power_inverse_unit
  import gfmpi_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  gfmpi_in_if.sink    in_i,
  gfmpi_out_if.source out_o
);

  logic [PcW-1:0]       pc_q, pc_d;
  logic [DigitIdxW-1:0] dig_q, dig_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [ExponentBits-1:0] exp_q, exp_d;
  elem_t acc_q, acc_d, x_q, x_d, b_q, b_d, p_q, p_d, mac_q, mac_d, res_q, res_d;
  logic inv_q, inv_d, restart_q, restart_d, out_valid_q, out_valid_d;

  ucode_t uw;
  logic   accept, out_free, cur_bit, taken;
  elem_t  mul_src, p_base, mac_sum;
  logic [NumDigits-1:0][DigitW-1:0] digits;

  // Fetch control word
  assign uw       = Ucode[pc_q];
  assign accept   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign cur_bit  = inv_q ? (cnt_q != CntW'(1)) : exp_q[ExponentBits-1];

  assign in_i.ready        = (pc_q == PcIdle);
  assign out_o.valid       = out_valid_q;
  assign out_o.result_low  = res_q[HalfW-1:0];
  assign out_o.result_high = res_q[ElemW-1:HalfW];

  // Evaluate jump condition
  always_comb begin
    unique case (uw.cond)
      CondNone:    taken = 1'b0;
      CondAlways:  taken = 1'b1;
      CondStart:   taken = !accept;
      CondMulBusy: taken = (dig_q != DigitIdxW'(NumDigits - 1));
      CondNoBit:   taken = !cur_bit;
      CondMore:    taken = (cnt_q != '0);
      CondOutBusy: taken = !out_free;
      default:     taken = 1'b0;
    endcase
  end

  // Advance step counter; the last step falls through to the idle step
  always_comb begin
    if (taken) begin
      pc_d = uw.target;
    end else if (uw.cond == CondStart) begin
      pc_d = entry_pc(in_i.command);
    end else if (pc_q == PcW'(NumSteps - 1)) begin
      pc_d = PcIdle;
    end else begin
      pc_d = pc_q + PcW'(1);
    end
  end

  // Multiplier operand digits, most significant first
  assign mul_src = uw.sel_b ? b_q : x_q;
  assign digits  = mul_src;
  assign p_base  = (dig_q == '0) ? '0 : p_q;
  assign mac_sum = (restart_q ? '0 : mac_q) ^ p_q;

  // Datapath driven by the control word
  always_comb begin
    acc_d       = acc_q;
    x_d         = x_q;
    b_d         = b_q;
    p_d         = p_q;
    mac_d       = mac_q;
    res_d       = res_q;
    dig_d       = dig_q;
    cnt_d       = cnt_q;
    exp_d       = exp_q;
    inv_d       = inv_q;
    restart_d   = restart_q;
    out_valid_d = out_valid_q && !out_o.ready;
    unique case (uw.op)
      OpIdle: begin
        if (accept) begin
          x_d       = {in_i.a_high, in_i.a_low};
          b_d       = {in_i.b_high, in_i.b_low};
          acc_d     = (in_i.command == CmdPow || in_i.command == CmdInv)
                    ? ElemW'(1) : {in_i.a_high, in_i.a_low};
          exp_d     = in_i.exponent[ExponentBits-1:0];
          inv_d     = (in_i.command == CmdInv);
          cnt_d     = (in_i.command == CmdInv) ? CntW'(InvIters) : CntW'(ExponentBits);
          restart_d = in_i.restart;
          dig_d     = '0;
        end
      end
      OpNop: begin
      end
      OpMul: begin
        p_d   = mul_step(p_base, acc_q, digits[DigitIdxW'(NumDigits - 1) - dig_q]);
        dig_d = dig_q + DigitIdxW'(1);
      end
      OpAccP: begin
        acc_d = p_q;
      end
      OpMacAdd: begin
        mac_d = mac_sum;
        acc_d = mac_sum;
      end
      OpSqr: begin
        acc_d = gf_square(acc_q);
        exp_d = exp_q << 1;
        cnt_d = cnt_q - CntW'(1);
      end
      OpOut: begin
        if (out_free) begin
          res_d       = acc_q;
          out_valid_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Hold control state and the multiply-accumulate sum under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= PcIdle;
      dig_q       <= '0;
      out_valid_q <= 1'b0;
      mac_q       <= '0;
    end else begin
      pc_q        <= pc_d;
      dig_q       <= dig_d;
      out_valid_q <= out_valid_d;
      mac_q       <= mac_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    acc_q     <= acc_d;
    x_q       <= x_d;
    b_q       <= b_d;
    p_q       <= p_d;
    res_q     <= res_d;
    cnt_q     <= cnt_d;
    exp_q     <= exp_d;
    inv_q     <= inv_d;
    restart_q <= restart_d;
  end

endmodule

// File: design/gfmpi_checker.sv
// Port-level checker for the GF(2^128) unit, bound to the top level.
module gfmpi_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [63:0] result_low_i,
  input logic [63:0] result_high_i
);

  logic [1:0] pend_q, pend_d;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;
  assign pend_d  = pend_q + {1'b0, in_acc} - {1'b0, out_acc};

  // Track items accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(result_low_i) && $stable(result_high_i))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_i)
    else $error("item accepted while previous item in progress");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pend_q != 2'd0)
    else $error("result without an accepted item");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("too many items outstanding");

endmodule

bind gf128_multiply_power_inverse_unit gfmpi_checker u_gfmpi_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .result_low_i  (out_o.result_low),
  .result_high_i (out_o.result_high)
);
